[design/deq_pkg.sv]
// Shared types, operation codes and status codes for the double-ended queue.
package deq_pkg;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_DUMP       = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] push_value;
    } deq_in_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
        logic               last;
    } deq_out_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_RD,
        S_DUMP_RD
    } deq_state_t;

    typedef struct packed {
        logic       push_front;
        logic       push_back;
        logic       pop_front;
        logic       pop_back;
        logic       dump_start;
        logic       dump_next;
        logic       load_imm;
        logic [1:0] imm_status;
        logic       load_rd;
        logic       rd_last;
    } deq_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic out_free;
        logic dump_last;
    } deq_stat_t;

endpackage

[design/deq_ctrl.sv]
// Controller state machine: decodes operations and sequences pops and dumps.
module deq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_func,
    input  deq_pkg::deq_stat_t stat,
    output deq_pkg::deq_cmd_t  cmd
);
    import deq_pkg::*;

    deq_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = stat.out_free;
                if (s_valid && stat.out_free) begin
                    unique case (s_func) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            cmd.load_imm = 1'b1;
                            if (stat.full) begin
                                cmd.imm_status = STAT_FULL;
                            end else begin
                                cmd.imm_status = STAT_OK;
                                cmd.push_front = (s_func == OP_PUSH_FRONT);
                                cmd.push_back  = (s_func == OP_PUSH_BACK);
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (stat.empty) begin
                                cmd.load_imm   = 1'b1;
                                cmd.imm_status = STAT_EMPTY;
                            end else begin
                                cmd.pop_front = (s_func == OP_POP_FRONT);
                                cmd.pop_back  = (s_func == OP_POP_BACK);
                                state_next    = S_POP_RD;
                            end
                        end
                        OP_DUMP: begin
                            if (stat.empty) begin
                                cmd.load_imm   = 1'b1;
                                cmd.imm_status = STAT_EMPTY;
                            end else begin
                                cmd.dump_start = 1'b1;
                                state_next     = S_DUMP_RD;
                            end
                        end
                        default: ;  // undefined operation: drop silently
                    endcase
                end
            end
            S_POP_RD: begin
                if (stat.out_free) begin
                    cmd.load_rd = 1'b1;
                    cmd.rd_last = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_DUMP_RD: begin
                if (stat.out_free) begin
                    cmd.load_rd = 1'b1;
                    cmd.rd_last = stat.dump_last;
                    if (stat.dump_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.dump_next = 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[design/deq_dpath.sv]
// Datapath: ring-buffer storage, front/occupancy pointers and result register.
module deq_dpath #(
    parameter int DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic signed [31:0] push_value,
    input  deq_pkg::deq_cmd_t  cmd,
    output deq_pkg::deq_stat_t stat,
    output logic               m_valid,
    input  logic               m_ready,
    output deq_pkg::deq_out_t  m_data
);
    import deq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [31:0]   mem_reg [DEPTH];
    logic [31:0]   rd_data_reg;
    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] left_reg, left_next;
    logic          out_valid_reg, out_valid_next;
    deq_out_t      out_reg, out_next;

    logic [SW-1:0] back_sum, tail_sum;
    logic [AW-1:0] back_idx, tail_idx, front_dec, front_inc, rd_inc;
    logic [AW-1:0] waddr, raddr;
    logic          wen, ren;

    // Ring arithmetic: one compare-and-subtract keeps indexes inside DEPTH.
    assign back_sum  = SW'(front_reg) + SW'(occ_reg);
    assign tail_sum  = back_sum - SW'(1);
    assign back_idx  = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
    assign tail_idx  = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + AW'(1);
    assign rd_inc    = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);

    always_comb begin
        front_next = front_reg;
        occ_next   = occ_reg;
        left_next  = left_reg;
        wen        = cmd.push_front | cmd.push_back;
        ren        = cmd.pop_front | cmd.pop_back | cmd.dump_start | cmd.dump_next;
        waddr      = cmd.push_front ? front_dec : back_idx;
        raddr      = front_reg;
        if (cmd.push_front) begin
            front_next = front_dec;
        end
        if (cmd.push_front || cmd.push_back) begin
            occ_next = occ_reg + CW'(1);
        end
        if (cmd.pop_front) begin
            front_next = front_inc;
        end
        if (cmd.pop_back) begin
            raddr = tail_idx;
        end
        if (cmd.pop_front || cmd.pop_back) begin
            occ_next = occ_reg - CW'(1);
        end
        if (cmd.dump_start) begin
            left_next = occ_reg;
        end
        if (cmd.dump_next) begin
            raddr     = rd_inc;
            left_next = left_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wen) begin
            mem_reg[waddr] <= push_value;
        end
        if (ren) begin
            rd_data_reg <= mem_reg[raddr];
            rd_ptr_reg  <= raddr;
        end
        left_reg <= left_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            front_reg     <= front_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg & ~m_ready;
        if (cmd.load_imm) begin
            out_next.value  = '0;
            out_next.status = cmd.imm_status;
            out_next.last   = 1'b1;
            out_valid_next  = 1'b1;
        end else if (cmd.load_rd) begin
            out_next.value  = rd_data_reg;
            out_next.status = STAT_OK;
            out_next.last   = cmd.rd_last;
            out_valid_next  = 1'b1;
        end
    end

    assign stat.empty     = (occ_reg == '0);
    assign stat.full      = (occ_reg == CW'(DEPTH));
    assign stat.out_free  = ~out_valid_reg | m_ready;
    assign stat.dump_last = (left_reg == CW'(1));

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

[design/double_ended_queue_unit.sv]
// Top level of the double-ended queue: controller plus ring-buffer datapath.
//
// A deque of DEPTH signed 32-bit words kept in a ring buffer. Each input beat
// carries one operation: push front, push back, pop front, pop back or dump.
// Pushes and pops give exactly one result beat (last set); a push on a full
// queue is dropped with status full, a pop on an empty queue returns status
// empty with value zero. A dump returns every stored word front to back, with
// last on the back word, and leaves the queue unchanged; a dump of an empty
// queue gives one empty beat. Operation codes 5 to 7 are dropped with no
// result. A push, or any empty/full case, is answered from the idle state; a pop
// waits in a read state as the storage read is registered; a dump reads one word
// at a time; no input is taken in those read states. The input is also held
// off while a result beat waits in the output register and the receiver is
// not ready; a beat leaving in the same cycle frees the register at once.
// No clearing pass is needed after reset: only occupied entries are ever read.
module double_ended_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  deq_pkg::deq_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output deq_pkg::deq_out_t m_data
);
    import deq_pkg::*;

    deq_cmd_t  cmd;
    deq_stat_t stat;

    // Decode operations and step through pop and dump reads.
    deq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_data.func),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Hold storage, pointers and the result register.
    deq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_value (s_data.push_value),
        .cmd        (cmd),
        .stat       (stat),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
